@@ rtl/rational_arithmetic_unit_top_defines.svh @@
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Assert that a condition implies a consequence on the same edge.
`define RAU_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence on the next edge.
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rau_pkg.sv @@
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int PW = 2 * OPERAND_WIDTH;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_NEG = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_ZERODEN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef logic [PW-1:0] t_wide;

    // Command and status between the sequencer and the divider.
    typedef struct packed {
        logic  start;
        t_wide dividend;
        t_wide divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_wide quot;
        t_wide rem;
    } t_div_rsp;

endpackage

@@ rtl/rau_div.sv @@
// Restoring divider, one quotient bit a cycle.
module rau_div import rau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(PW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    t_wide         r_q;
    t_wide         r_r;
    t_wide         r_d;
    logic          r_done;
    logic [PW:0]   w_trial;
    t_wide         w_shift;

    // Shift in the next dividend bit and try the subtraction.
    assign w_shift = {r_r[PW-2:0], r_q[PW-1]};
    assign w_trial = {r_r, r_q[PW-1]} - {1'b0, r_d};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_trial[PW]) begin
                r_r <= w_trial[PW-1:0];
                r_q <= {r_q[PW-2:0], 1'b1};
            end else begin
                r_r <= w_shift;
                r_q <= {r_q[PW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

@@ rtl/rational_arithmetic_unit_top.sv @@
// Channel   Direction  Handshake                 Payload
// command   in         start while !busy          i_cmd, i_a_num, i_a_den, i_b_num, i_b_den
// result    out        o_valid, one cycle         o_res_num, o_res_den, o_status
//
// A word with a zero denominator or a zero divisor goes from idle straight to the output state.
// The cross products come from one 32x32 multiplier, one product a cycle. The GCD runs
// as Euclid's algorithm on the shared 64-bit restoring divider, taking at most about 92
// remainders; two more divisions reduce numerator and denominator.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The receiver cannot stall: each result is shown for one cycle.
`include "rational_arithmetic_unit_top_defines.svh"

module rational_arithmetic_unit_top import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic        o_valid,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_status
);

    localparam int OW = OPERAND_WIDTH;
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_GW   = 4'd6;
    localparam logic [3:0] S_DN   = 4'd7;
    localparam logic [3:0] S_DNW  = 4'd8;
    localparam logic [3:0] S_DD   = 4'd9;
    localparam logic [3:0] S_DDW  = 4'd10;
    localparam logic [3:0] S_CHK  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // Internal marker: both cross products are waiting to be added.
    localparam logic [2:0] CMD_SUM_PEND = 3'd7;

    logic [3:0]    r_state;
    logic [2:0]    r_cmd;
    logic [OW-1:0] r_anm, r_adm, r_bnm, r_bdm;
    logic          r_ans, r_ads, r_bns, r_bds;
    t_wide         r_p0, r_p1, r_den, r_num, r_x, r_y, r_nq;
    logic          r_s0, r_s1, r_nneg, r_dneg;
    logic          r_valid;
    logic signed [31:0] r_rn;
    logic [30:0]   r_rd;
    logic [1:0]    r_st;
    logic [OW-1:0] w_ma, w_mb;
    t_wide         w_prod;
    t_div_req      w_req;
    t_div_rsp      w_rsp;
    logic          w_neg;
    t_wide         w_half;

    // Magnitude of one operand.
    function automatic logic [OW-1:0] f_mag(input logic [31:0] v);
        logic [OW-1:0] t;
        t = v[OW-1:0];
        return t[OW-1] ? (~t + 1'b1) : t;
    endfunction

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Shared multiplier operand select.
    always_comb begin
        case (r_state)
            S_M0: begin
                w_ma = r_anm;
                w_mb = (r_cmd == CMD_DIV) ? r_bdm : (r_cmd == CMD_MUL ? r_bnm : r_bdm);
            end
            S_M1: begin
                w_ma = r_adm;
                w_mb = (r_cmd == CMD_DIV) ? r_bnm : r_bdm;
            end
            S_M2: begin
                w_ma = r_adm;
                w_mb = r_bnm;
            end
            default: begin
                w_ma = r_anm;
                w_mb = r_bdm;
            end
        endcase
    end
    assign w_prod = PW'(w_ma) * PW'(w_mb);
    assign w_neg  = (r_nneg != r_dneg) && (r_num != '0);
    assign w_half = t_wide'(1) << (OW - 1);

    // Divider request.
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_x;
        w_req.divisor  = r_y;
        case (r_state)
            S_GCD: w_req.start = (r_y != '0);
            S_DN: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_num;
                w_req.divisor  = r_x;
            end
            S_DD: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_den;
                w_req.divisor  = r_x;
            end
            default: w_req.start = 1'b0;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= i_cmd;
                        r_anm <= f_mag(i_a_num);
                        r_adm <= f_mag(i_a_den);
                        r_bnm <= f_mag(i_b_num);
                        r_bdm <= f_mag(i_b_den);
                        r_ans <= i_a_num[OW-1];
                        r_ads <= i_a_den[OW-1];
                        r_bns <= i_b_num[OW-1] ^ (i_cmd == CMD_SUB);
                        r_bds <= i_b_den[OW-1];
                        r_rn  <= '0;
                        r_rd  <= '0;
                        if (i_a_den[OW-1:0] == '0 ||
                            (i_cmd <= CMD_DIV && i_b_den[OW-1:0] == '0)) begin
                            r_st    <= ST_ZERODEN;
                            r_state <= S_OUT;
                        end else if (i_cmd == CMD_DIV && i_b_num[OW-1:0] == '0) begin
                            r_st    <= ST_DIVZERO;
                            r_state <= S_OUT;
                        end else begin
                            r_st    <= ST_OK;
                            r_state <= S_M0;
                        end
                    end
                end
                S_M0: begin
                    if (r_cmd > CMD_DIV) begin
                        // Negate, also taken by the unused command codes.
                        r_num   <= PW'(r_anm);
                        r_nneg  <= ~r_ans;
                        r_den   <= PW'(r_adm);
                        r_dneg  <= r_ads;
                        r_cmd   <= CMD_NEG;
                        r_state <= S_SUM;
                    end else begin
                        r_p0 <= w_prod;
                        r_s0 <= r_ans ^ ((r_cmd == CMD_MUL) ? r_bns : r_bds);
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    r_den  <= w_prod;
                    r_dneg <= r_ads ^ ((r_cmd == CMD_DIV) ? r_bns : r_bds);
                    if (r_cmd >= CMD_MUL) begin
                        r_num   <= r_p0;
                        r_nneg  <= r_s0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    // Second cross product; the signed-magnitude add of the two follows in S_SUM.
                    r_p1 <= w_prod;
                    r_s1 <= r_ads ^ r_bns;
                    r_state <= S_SUM;
                    r_cmd <= CMD_SUM_PEND;
                end
                S_SUM: begin
                    if (r_cmd == CMD_SUM_PEND) begin
                        if (r_s0 == r_s1) begin
                            r_num  <= r_p0 + r_p1;
                            r_nneg <= r_s0;
                        end else if (r_p0 >= r_p1) begin
                            r_num  <= r_p0 - r_p1;
                            r_nneg <= r_s0;
                        end else begin
                            r_num  <= r_p1 - r_p0;
                            r_nneg <= r_s1;
                        end
                        r_cmd <= CMD_ADD;
                    end else begin
                        r_x     <= r_num;
                        r_y     <= r_den;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_y == '0) r_state <= S_DN;
                    else r_state <= S_GW;
                end
                S_GW: begin
                    if (w_rsp.done) begin
                        r_x     <= r_y;
                        r_y     <= w_rsp.rem;
                        r_state <= S_GCD;
                    end
                end
                S_DN: r_state <= S_DNW;
                S_DNW: begin
                    if (w_rsp.done) begin
                        r_nq    <= w_rsp.quot;
                        r_state <= S_DD;
                    end
                end
                S_DD: r_state <= S_DDW;
                S_DDW: begin
                    if (w_rsp.done) begin
                        r_den   <= w_rsp.quot;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_nq > (w_neg ? w_half : w_half - 1'b1) ||
                        r_den > w_half - 1'b1) begin
                        r_st <= ST_OVERFLOW;
                    end else begin
                        r_rn <= 32'(signed'(w_neg ? (~r_nq[OW-1:0] + 1'b1) : r_nq[OW-1:0]));
                        r_rd <= 31'(r_den);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_res_num = r_rn;
    assign o_res_den = r_rd;
    assign o_status  = r_st;

    // A result appears only when the sequencer is back in idle.
    `RAU_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE, "result outside idle")
    // A word accepted in idle makes the block busy.
    `RAU_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")
    // A failing status carries a zero fraction.
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_valid && r_st != ST_OK, r_rn == '0 && r_rd == '0, "error result not zero")

endmodule
